// File: rtl/djbks_pkg.sv
// Shared constants and codes for the hashed key set.
// No dependencies; compile first.
package djbks_pkg;

    // Hash seed and the shift that forms the times-33 step.
    localparam logic [63:0] HASH_SEED  = 64'd5381;
    localparam int          HASH_SHIFT = 5;

    // Field widths of the channels.
    localparam int REQ_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 12;
    localparam int HASH_W  = 64;
    localparam int CFG_W   = 9;

    // Request codes; the unused code acts as a lookup.
    typedef enum logic [REQ_W-1:0] {
        REQ_ADD      = 2'd0,
        REQ_CONTAINS = 2'd1,
        REQ_REMOVE   = 2'd2,
        REQ_SPARE    = 2'd3
    } t_req;

endpackage

// File: rtl/djbks_in_if.sv
// Channel interfaces for key bytes and results.
// Depends on djbks_pkg.
interface djbks_in_if;
    logic                         valid;
    logic                         ready;
    logic [djbks_pkg::REQ_W-1:0]  req_type;
    logic [djbks_pkg::BYTE_W-1:0] key_byte;
    logic                         key_last;

    modport source (output valid, req_type, key_byte, key_last, input ready);
    modport sink   (input valid, req_type, key_byte, key_last, output ready);
endinterface

interface djbks_out_if;
    logic                          valid;
    logic                          ready;
    logic                          is_member;
    logic                          status;
    logic [djbks_pkg::COUNT_W-1:0] member_count;
    logic [djbks_pkg::HASH_W-1:0]  key_hash;

    modport source (output valid, is_member, status, member_count, key_hash,
                    input ready);
    modport sink   (input valid, is_member, status, member_count, key_hash,
                    output ready);
endinterface

// File: rtl/djb2_hashed_key_set.sv
// Top level of the hashed key set: djb2 hashing, bucket division and
// the table scan. Depends on djbks_pkg and the channel interfaces.
//
// Key bytes are taken one per cycle while the block is idle and fold into a
// running djb2 hash. On the last byte the block stops taking input: the hash
// is divided by the bucket count in a bit-serial divider, the bucket's fill
// count is read and checked, the stored hashes are read and compared one
// entry at a time through the single read port of the entry memory, and the
// update and the result are written together once the output register is
// free. The result waits in an output register; bytes of the next key are
// taken meanwhile.
// Fill counts are cleared at reset through one valid bit per bucket, so
// no clearing pass is needed.
module djb2_hashed_key_set #(
    parameter int MAX_BUCKETS  = 256,
    parameter int BUCKET_DEPTH = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [djbks_pkg::CFG_W-1:0] i_cfg_data,
    djbks_in_if.sink                i_in,
    djbks_out_if.source             o_out
);
    import djbks_pkg::*;

    localparam int BW    = $clog2(MAX_BUCKETS + 1);
    localparam int BKW   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int FW    = $clog2(BUCKET_DEPTH + 1);
    localparam int ENTRIES = MAX_BUCKETS * BUCKET_DEPTH;
    localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int DCW   = $clog2(HASH_W);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_FRD  = 7'b0000100,
        S_FCHK = 7'b0001000,
        S_SRD  = 7'b0010000,
        S_SCMP = 7'b0100000,
        S_UPD  = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    logic [CFG_W-1:0]      r_bucket_count;
    logic [HASH_W-1:0]     r_hash;
    logic [HASH_W-1:0]     r_key_hash;
    t_req                  r_req;
    logic [HASH_W-1:0]     r_dividend;
    logic [BW-1:0]         r_rem;
    logic [DCW-1:0]        r_dcnt;
    logic [FW-1:0]         r_fill;
    logic [FW-1:0]         r_idx;
    logic                  r_found;
    logic                  r_present;
    logic [FW-1:0]         r_fidx;
    logic [COUNT_W-1:0]    r_count;
    logic [MAX_BUCKETS-1:0] r_bvalid;

    // Output register.
    logic                  r_out_valid;
    logic                  r_out_member;
    logic                  r_out_status;
    logic [COUNT_W-1:0]    r_out_count;
    logic [HASH_W-1:0]     r_out_hash;

    // Memories.
    logic [HASH_W:0]       entry_mem [ENTRIES];
    logic [FW-1:0]         fill_mem  [MAX_BUCKETS];
    logic [HASH_W:0]       r_entry_rd;
    logic [FW-1:0]         r_fill_rd;

    logic                  in_xfer;
    logic                  out_free;
    logic [BW-1:0]         eff_buckets;
    logic [BW:0]           div_trial;
    logic [BW:0]           div_sub;
    logic [BKW-1:0]        bucket;
    logic [AW-1:0]         base_addr;
    logic [AW-1:0]         entry_raddr;
    logic                  entry_we;
    logic [AW-1:0]         entry_waddr;
    logic [HASH_W:0]       entry_wdata;
    logic                  fill_we;
    logic [FW-1:0]         fill_val;
    logic                  upd_member;
    logic                  upd_status;
    logic [COUNT_W-1:0]    upd_count;
    logic [HASH_W-1:0]     folded;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // Bucket count in use, clamped into one to MAX_BUCKETS.
    always_comb begin
        if (r_bucket_count == '0) begin
            eff_buckets = BW'(1);
        end else if (32'(r_bucket_count) > MAX_BUCKETS) begin
            eff_buckets = BW'(MAX_BUCKETS);
        end else begin
            eff_buckets = BW'(r_bucket_count);
        end
    end

    // One restoring division step per cycle.
    assign div_trial = {r_rem, r_dividend[HASH_W-1]};
    assign div_sub   = div_trial - {1'b0, eff_buckets};

    assign bucket    = BKW'(r_rem);
    assign base_addr = AW'(bucket) * AW'(BUCKET_DEPTH);
    assign entry_raddr = base_addr + AW'(r_idx);

    // Hash step: times 33 plus the sign-extended byte; a zero byte leaves the hash.
    assign folded = (i_in.key_byte == '0) ? r_hash :
                    (r_hash << HASH_SHIFT) + r_hash
                    + {{(HASH_W-BYTE_W){i_in.key_byte[BYTE_W-1]}}, i_in.key_byte};

    // Fill count as read; an untouched bucket reads zero.
    always_comb begin
        fill_val = r_bvalid[bucket] ? r_fill_rd : '0;
        if (32'(fill_val) > BUCKET_DEPTH) begin
            fill_val = FW'(BUCKET_DEPTH);
        end
    end

    // Table update for the finished scan.
    always_comb begin
        entry_we    = 1'b0;
        entry_waddr = base_addr + AW'(r_fidx);
        entry_wdata = {1'b1, r_key_hash};
        fill_we     = 1'b0;
        upd_member  = 1'b0;
        upd_status  = 1'b0;
        upd_count   = r_count;
        case (r_req)
            REQ_ADD: begin
                if (r_found) begin
                    entry_we   = 1'b1;
                    upd_member = 1'b1;
                    if (!r_present) begin
                        upd_count = r_count + COUNT_W'(1);
                    end
                end else if (32'(r_fill) < BUCKET_DEPTH) begin
                    entry_we    = 1'b1;
                    entry_waddr = base_addr + AW'(r_fill);
                    fill_we     = 1'b1;
                    upd_member  = 1'b1;
                    upd_count   = r_count + COUNT_W'(1);
                end else begin
                    upd_status = 1'b1;
                end
            end
            REQ_REMOVE: begin
                if (r_found) begin
                    entry_we    = 1'b1;
                    entry_wdata = {1'b0, r_key_hash};
                    if (r_present) begin
                        upd_count = r_count - COUNT_W'(1);
                    end
                end
            end
            default: begin
                upd_member = r_found && r_present;
            end
        endcase
        if (!(r_state == S_UPD && out_free)) begin
            entry_we = 1'b0;
            fill_we  = 1'b0;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_xfer && i_in.key_last) n_state = S_DIV;
            S_DIV:  if (r_dcnt == DCW'(HASH_W - 1)) n_state = S_FRD;
            S_FRD:  n_state = S_FCHK;
            S_FCHK: n_state = (fill_val == '0) ? S_UPD : S_SRD;
            S_SRD:  n_state = S_SCMP;
            S_SCMP: begin
                if (r_entry_rd[HASH_W-1:0] == r_key_hash || r_idx + FW'(1) == r_fill) begin
                    n_state = S_UPD;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_UPD:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_bucket_count <= CFG_W'(256);
            r_hash         <= HASH_SEED;
            r_count        <= '0;
            r_bvalid       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_bucket_count <= i_cfg_data;
            end
            if (in_xfer) begin
                r_hash <= i_in.key_last ? HASH_SEED : folded;
            end
            if (r_state == S_UPD && out_free) begin
                r_count     <= upd_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (fill_we) begin
                r_bvalid[bucket] <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in.key_last) begin
            r_key_hash <= folded;
            r_dividend <= folded;
            r_req      <= t_req'(i_in.req_type);
            r_rem      <= '0;
            r_dcnt     <= '0;
        end
        if (r_state == S_DIV) begin
            r_dividend <= r_dividend << 1;
            r_rem      <= div_sub[BW] ? BW'(div_trial) : BW'(div_sub);
            r_dcnt     <= r_dcnt + DCW'(1);
        end
        if (r_state == S_FCHK) begin
            r_fill  <= fill_val;
            r_idx   <= '0;
            r_found <= 1'b0;
        end
        if (r_state == S_SCMP) begin
            if (r_entry_rd[HASH_W-1:0] == r_key_hash) begin
                r_found   <= 1'b1;
                r_present <= r_entry_rd[HASH_W];
                r_fidx    <= r_idx;
            end
            r_idx <= r_idx + FW'(1);
        end
        if (r_state == S_UPD && out_free) begin
            r_out_member <= upd_member;
            r_out_status <= upd_status;
            r_out_count  <= upd_count;
            r_out_hash   <= r_key_hash;
        end
    end

    // Entry memory: hash plus present mark.
    always_ff @(posedge i_clk) begin
        if (entry_we) begin
            entry_mem[entry_waddr] <= entry_wdata;
        end
        r_entry_rd <= entry_mem[entry_raddr];
    end

    // Fill count memory, one word per bucket.
    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            fill_mem[bucket] <= r_fill + FW'(1);
        end
        r_fill_rd <= fill_mem[bucket];
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.is_member    = r_out_member;
    assign o_out.status       = r_out_status;
    assign o_out.member_count = r_out_count;
    assign o_out.key_hash     = r_out_hash;

`ifndef SYNTHESIS
    // The hash restarts from the seed after every last byte.
    a_seed_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.key_last) |=> (r_hash == HASH_SEED))
        else $error("running hash not reseeded");

    // The scan never reads past the bucket's fill.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRD) |-> (r_idx < r_fill))
        else $error("scan index beyond fill");

    // The member count cannot exceed the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= ENTRIES)
        else $error("member count overflow");

    // A bucket remainder always lies below the bucket count.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRD) |-> (r_rem < eff_buckets))
        else $error("bucket remainder out of range");
`endif

endmodule
